// ===== design/gddw_pkg.sv =====
// Shared widths, constants, command codes and the month table for the
// Gregorian day difference and weekday block. No dependencies.
`default_nettype none

package gddw_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int WD_W    = 3;

    // Day numbers of the largest 14-bit year still fit in 23 bits.
    localparam int DN_W    = 23;
    localparam int CUM_W   = 9;

    // Year arithmetic: quarter of a year count and division by 25 through a reciprocal.
    localparam int Q4_W        = YEAR_W - 2;
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = 25;
    localparam int Q100_W      = 8;
    localparam int DAYS_PER_YEAR = 365;
    localparam int CENTURY_QUARTERS = 25;

    // Modulo-seven folding of a day number in 3-bit groups (8 is 1 modulo 7).
    localparam int FOLD_GROUPS = (DN_W + 2) / 3;
    localparam int FOLD_W      = 6;
    localparam int DAYS_PER_WEEK = 7;

    // Lanes: date A, date B and January 1 of the base year.
    localparam int NUM_LANES = 3;
    localparam int LANE_A    = 0;
    localparam int LANE_B    = 1;
    localparam int LANE_BASE = 2;

    // Pipeline depth.
    localparam int NUM_STAGES = 6;

    // Configuration and parameter defaults.
    localparam int unsigned MAX_YEAR_DEFAULT = 9999;
    localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 14'd1600;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    // Saturation limits of the difference.
    localparam logic signed [DN_W:0] DIFF_MAX = 24'sd4194303;
    localparam logic signed [DN_W:0] DIFF_MIN = -24'sd4194304;

    typedef enum logic {
        CMD_DIFF    = 1'b0,
        CMD_WEEKDAY = 1'b1
    } cmd_t;

    // Days in the months before the given month. Month zero counts as January
    // and months above twelve count the whole year.
    function automatic logic [CUM_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
        logic [CUM_W-1:0] days;
        unique case (month)
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            4'd12:      days = 9'd334;
            default:    days = 9'd365;
        endcase
        if (leap && (month >= 4'd3))
        begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== design/gregorian_day_difference_weekday.sv =====
// Gregorian day difference and weekday: a six-stage pipeline over three date lanes.
// Depends on gddw_pkg for widths, constants, command codes and the month table.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one transaction per query: a
//   command and two dates A and B. The output channel (out_valid, out_stall)
//   returns one transaction per query, in order. Command zero gives the signed
//   days from A to B in day_difference; command one gives the weekday of A,
//   counted from January 1 of base_year, in weekday. The other field is zero.
//   base_year is to be written through cfg_we and cfg_wdata only while no
//   query is in flight; the block does not enforce this. Throughput is one
//   transaction per cycle while out_stall is low: every date is turned into
//   a day number by a fixed chain of stages (year clamp, reciprocal multiplies,
//   leap test, month table, subtract and modulo-seven fold), with no iteration.
//   A stall from the receiver holds the output register; the stages behind it
//   keep filling empty slots, and in_stall rises only when all six are full.
//   Reset clears every stage valid bit and sets base_year to 1600.
`default_nettype none

module gregorian_day_difference_weekday #(
    parameter int unsigned MAX_YEAR = gddw_pkg::MAX_YEAR_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [gddw_pkg::YEAR_W-1:0]         cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                command,
    input  wire logic [gddw_pkg::DAY_W-1:0]          a_day,
    input  wire logic [gddw_pkg::MONTH_W-1:0]        a_month,
    input  wire logic [gddw_pkg::YEAR_W-1:0]         a_year,
    input  wire logic [gddw_pkg::DAY_W-1:0]          b_day,
    input  wire logic [gddw_pkg::MONTH_W-1:0]        b_month,
    input  wire logic [gddw_pkg::YEAR_W-1:0]         b_year,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [gddw_pkg::DIFF_W-1:0]       day_difference,
    output logic [gddw_pkg::WD_W-1:0]                weekday
);

    localparam int L = gddw_pkg::NUM_LANES;
    localparam int S = gddw_pkg::NUM_STAGES;

    // Configuration register.
    logic [gddw_pkg::YEAR_W-1:0] base_year_reg;

    // Stage valid bits and advance enables.
    logic [S-1:0] vld_reg;
    logic [S-1:0] vld_next;
    logic [S-1:0] en;

    // Lane sources.
    logic [gddw_pkg::YEAR_W-1:0]  raw_year  [L];
    logic [gddw_pkg::MONTH_W-1:0] raw_month [L];
    logic [gddw_pkg::DAY_W-1:0]   raw_day   [L];

    // Stage 1: clamped year.
    gddw_pkg::cmd_t               s1_cmd_reg;
    logic [gddw_pkg::YEAR_W-1:0]  s1_y_reg     [L];
    logic [gddw_pkg::YEAR_W-1:0]  s1_y_next    [L];
    logic [gddw_pkg::MONTH_W-1:0] s1_month_reg [L];
    logic [gddw_pkg::DAY_W-1:0]   s1_day_reg   [L];

    // Stage 2: products.
    gddw_pkg::cmd_t               s2_cmd_reg;
    logic [gddw_pkg::DN_W-1:0]    s2_p365_reg    [L];
    logic [gddw_pkg::DN_W-1:0]    s2_p365_next   [L];
    logic [gddw_pkg::Q4_W-1:0]    s2_q4_reg      [L];
    logic [gddw_pkg::Q4_W-1:0]    s2_q4_next     [L];
    logic [gddw_pkg::PROD_W-1:0]  s2_prod_reg    [L];
    logic [gddw_pkg::PROD_W-1:0]  s2_prod_next   [L];
    logic [gddw_pkg::Q4_W-1:0]    s2_yq4_reg     [L];
    logic [gddw_pkg::PROD_W-1:0]  s2_prody_reg   [L];
    logic [gddw_pkg::PROD_W-1:0]  s2_prody_next  [L];
    logic [1:0]                   s2_ylo_reg     [L];
    logic [gddw_pkg::MONTH_W-1:0] s2_month_reg   [L];
    logic [gddw_pkg::DAY_W-1:0]   s2_day_reg     [L];
    logic [gddw_pkg::YEAR_W-1:0]  p_c            [L];

    // Stage 3: days before the year and the leap flag.
    gddw_pkg::cmd_t               s3_cmd_reg;
    logic [gddw_pkg::DN_W-1:0]    s3_dby_reg    [L];
    logic [gddw_pkg::DN_W-1:0]    s3_dby_next   [L];
    logic                         s3_leap_reg   [L];
    logic                         s3_leap_next  [L];
    logic [gddw_pkg::MONTH_W-1:0] s3_month_reg  [L];
    logic [gddw_pkg::DAY_W-1:0]   s3_day_reg    [L];
    logic [gddw_pkg::Q100_W-1:0]  q100_c        [L];
    logic [gddw_pkg::Q100_W-1:0]  qy_c          [L];
    logic [gddw_pkg::Q4_W-1:0]    r25_c         [L];
    logic                         div4_c        [L];
    logic                         div100_c      [L];

    // Stage 4: day numbers.
    gddw_pkg::cmd_t               s4_cmd_reg;
    logic [gddw_pkg::DN_W-1:0]    s4_dn_reg     [L];
    logic [gddw_pkg::DN_W-1:0]    s4_dn_next    [L];

    // Stage 5: saturated difference and first modulo-seven fold.
    gddw_pkg::cmd_t                    s5_cmd_reg;
    logic signed [gddw_pkg::DIFF_W-1:0] s5_diff_reg;
    logic signed [gddw_pkg::DIFF_W-1:0] s5_diff_next;
    logic [gddw_pkg::FOLD_W-1:0]       s5_fold_a_reg;
    logic [gddw_pkg::FOLD_W-1:0]       s5_fold_base_reg;
    logic signed [gddw_pkg::DN_W:0]    diff_c;

    // Stage 6: output register.
    logic signed [gddw_pkg::DIFF_W-1:0] out_diff_reg;
    logic signed [gddw_pkg::DIFF_W-1:0] out_diff_next;
    logic [gddw_pkg::WD_W-1:0]          out_wd_reg;
    logic [gddw_pkg::WD_W-1:0]          out_wd_next;
    logic [gddw_pkg::WD_W-1:0]          rem_a_c;
    logic [gddw_pkg::WD_W-1:0]          rem_base_c;
    logic [gddw_pkg::WD_W:0]            rem_diff_c;

    // Sum of the 3-bit groups of a day number; congruent to it modulo seven.
    function automatic logic [gddw_pkg::FOLD_W-1:0] fold7(input logic [gddw_pkg::DN_W-1:0] x);
        logic [3*gddw_pkg::FOLD_GROUPS-1:0] xp;
        logic [gddw_pkg::FOLD_W-1:0]        acc;
        xp  = (3*gddw_pkg::FOLD_GROUPS)'(x);
        acc = '0;
        for (int g = 0; g < gddw_pkg::FOLD_GROUPS; g++)
        begin
            acc = acc + gddw_pkg::FOLD_W'(xp[3*g +: 3]);
        end
        return acc;
    endfunction

    // Finish the reduction of a folded sum (at most 56) to 0..6.
    function automatic logic [gddw_pkg::WD_W-1:0] finish7(input logic [gddw_pkg::FOLD_W-1:0] f);
        logic [3:0] t;
        logic [3:0] u;
        t = 4'(f[5:3]) + 4'(f[2:0]);
        u = 4'(t[3]) + 4'(t[2:0]);
        if (u >= 4'(gddw_pkg::DAYS_PER_WEEK))
        begin
            u = u - 4'(gddw_pkg::DAYS_PER_WEEK);
        end
        return u[2:0];
    endfunction

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        en[S-1] = !vld_reg[S-1] || !out_stall;
        for (int k = S - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < S; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            base_year_reg <= gddw_pkg::BASE_YEAR_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_we)
            begin
                base_year_reg <= cfg_wdata;
            end
        end
    end

    // Stage 1 logic: pick lane sources and clamp each year to 1..MAX_YEAR.
    always_comb
    begin
        raw_year[gddw_pkg::LANE_A]     = a_year;
        raw_month[gddw_pkg::LANE_A]    = a_month;
        raw_day[gddw_pkg::LANE_A]      = a_day;
        raw_year[gddw_pkg::LANE_B]     = b_year;
        raw_month[gddw_pkg::LANE_B]    = b_month;
        raw_day[gddw_pkg::LANE_B]      = b_day;
        raw_year[gddw_pkg::LANE_BASE]  = base_year_reg;
        raw_month[gddw_pkg::LANE_BASE] = gddw_pkg::MONTH_JAN;
        raw_day[gddw_pkg::LANE_BASE]   = gddw_pkg::DAY_FIRST;
        for (int i = 0; i < L; i++)
        begin
            if (raw_year[i] == '0)
            begin
                s1_y_next[i] = gddw_pkg::YEAR_W'(1);
            end
            else if (32'(raw_year[i]) > MAX_YEAR)
            begin
                s1_y_next[i] = gddw_pkg::YEAR_W'(MAX_YEAR);
            end
            else
            begin
                s1_y_next[i] = raw_year[i];
            end
        end
    end

    // Stage 2 logic: 365 times the years before, and reciprocal products for /100.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            p_c[i]           = s1_y_reg[i] - gddw_pkg::YEAR_W'(1);
            s2_p365_next[i]  = gddw_pkg::DN_W'(p_c[i])
                             * gddw_pkg::DN_W'(gddw_pkg::DAYS_PER_YEAR);
            s2_q4_next[i]    = p_c[i][gddw_pkg::YEAR_W-1:2];
            s2_prod_next[i]  = gddw_pkg::PROD_W'(s2_q4_next[i])
                             * gddw_pkg::PROD_W'(gddw_pkg::RECIP_25);
            s2_prody_next[i] = gddw_pkg::PROD_W'(s1_y_reg[i][gddw_pkg::YEAR_W-1:2])
                             * gddw_pkg::PROD_W'(gddw_pkg::RECIP_25);
        end
    end

    // Stage 3 logic: days in all earlier years, and the leap test of the year.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            q100_c[i] = gddw_pkg::Q100_W'(s2_prod_reg[i] >> gddw_pkg::RECIP_SHIFT);
            s3_dby_next[i] = s2_p365_reg[i]
                           + gddw_pkg::DN_W'(s2_q4_reg[i])
                           - gddw_pkg::DN_W'(q100_c[i])
                           + gddw_pkg::DN_W'(q100_c[i][gddw_pkg::Q100_W-1:2]);
            qy_c[i]     = gddw_pkg::Q100_W'(s2_prody_reg[i] >> gddw_pkg::RECIP_SHIFT);
            r25_c[i]    = s2_yq4_reg[i] - gddw_pkg::Q4_W'(qy_c[i])
                        * gddw_pkg::Q4_W'(gddw_pkg::CENTURY_QUARTERS);
            div4_c[i]   = (s2_ylo_reg[i] == 2'd0);
            div100_c[i] = div4_c[i] && (r25_c[i] == '0);
            s3_leap_next[i] = (div4_c[i] && !div100_c[i])
                            || (div100_c[i] && (qy_c[i][1:0] == 2'd0));
        end
    end

    // Stage 4 logic: add the earlier months and the day of the month.
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            s4_dn_next[i] = s3_dby_reg[i]
                          + gddw_pkg::DN_W'(gddw_pkg::cum_days(s3_leap_reg[i], s3_month_reg[i]))
                          + gddw_pkg::DN_W'(s3_day_reg[i]);
        end
    end

    // Stage 5 logic: signed difference with saturation.
    always_comb
    begin
        diff_c = $signed({1'b0, s4_dn_reg[gddw_pkg::LANE_B]})
               - $signed({1'b0, s4_dn_reg[gddw_pkg::LANE_A]});
        if (diff_c > gddw_pkg::DIFF_MAX)
        begin
            s5_diff_next = gddw_pkg::DIFF_W'(gddw_pkg::DIFF_MAX);
        end
        else if (diff_c < gddw_pkg::DIFF_MIN)
        begin
            s5_diff_next = gddw_pkg::DIFF_W'(gddw_pkg::DIFF_MIN);
        end
        else
        begin
            s5_diff_next = gddw_pkg::DIFF_W'(diff_c);
        end
    end

    // Stage 6 logic: weekday as the nonnegative difference of the two remainders.
    always_comb
    begin
        rem_a_c    = finish7(s5_fold_a_reg);
        rem_base_c = finish7(s5_fold_base_reg);
        rem_diff_c = {1'b0, rem_a_c} - {1'b0, rem_base_c};
        if (rem_diff_c[gddw_pkg::WD_W])
        begin
            rem_diff_c = rem_diff_c + (gddw_pkg::WD_W+1)'(gddw_pkg::DAYS_PER_WEEK);
        end
        unique case (s5_cmd_reg)
            gddw_pkg::CMD_DIFF:
            begin
                out_diff_next = s5_diff_reg;
                out_wd_next   = '0;
            end
            gddw_pkg::CMD_WEEKDAY:
            begin
                out_diff_next = '0;
                out_wd_next   = rem_diff_c[gddw_pkg::WD_W-1:0];
            end
            default:
            begin
                out_diff_next = '0;
                out_wd_next   = '0;
            end
        endcase
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_cmd_reg <= gddw_pkg::cmd_t'(command);
            for (int i = 0; i < L; i++)
            begin
                s1_y_reg[i]     <= s1_y_next[i];
                s1_month_reg[i] <= raw_month[i];
                s1_day_reg[i]   <= raw_day[i];
            end
        end
        if (en[1])
        begin
            s2_cmd_reg <= s1_cmd_reg;
            for (int i = 0; i < L; i++)
            begin
                s2_p365_reg[i]  <= s2_p365_next[i];
                s2_q4_reg[i]    <= s2_q4_next[i];
                s2_prod_reg[i]  <= s2_prod_next[i];
                s2_yq4_reg[i]   <= s1_y_reg[i][gddw_pkg::YEAR_W-1:2];
                s2_prody_reg[i] <= s2_prody_next[i];
                s2_ylo_reg[i]   <= s1_y_reg[i][1:0];
                s2_month_reg[i] <= s1_month_reg[i];
                s2_day_reg[i]   <= s1_day_reg[i];
            end
        end
        if (en[2])
        begin
            s3_cmd_reg <= s2_cmd_reg;
            for (int i = 0; i < L; i++)
            begin
                s3_dby_reg[i]   <= s3_dby_next[i];
                s3_leap_reg[i]  <= s3_leap_next[i];
                s3_month_reg[i] <= s2_month_reg[i];
                s3_day_reg[i]   <= s2_day_reg[i];
            end
        end
        if (en[3])
        begin
            s4_cmd_reg <= s3_cmd_reg;
            for (int i = 0; i < L; i++)
            begin
                s4_dn_reg[i] <= s4_dn_next[i];
            end
        end
        if (en[4])
        begin
            s5_cmd_reg       <= s4_cmd_reg;
            s5_diff_reg      <= s5_diff_next;
            s5_fold_a_reg    <= fold7(s4_dn_reg[gddw_pkg::LANE_A]);
            s5_fold_base_reg <= fold7(s4_dn_reg[gddw_pkg::LANE_BASE]);
        end
        if (en[5])
        begin
            out_diff_reg <= out_diff_next;
            out_wd_reg   <= out_wd_next;
        end
    end

    assign out_valid      = vld_reg[S-1];
    assign day_difference = out_diff_reg;
    assign weekday        = out_wd_reg;

`ifndef ASSERT_OFF
    // Only one of the two result fields can be nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_difference == '0 || weekday == '0))
        else $error("both result fields are nonzero");

    // The weekday is always reduced to 0..6.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weekday < 3'(gddw_pkg::DAYS_PER_WEEK)))
        else $error("weekday out of range");

    // The input is held off only when every stage holds a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // A transaction that is not taken at the output stays there.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S-1] && out_stall) |=> vld_reg[S-1])
        else $error("output transaction dropped under stall");
`endif

endmodule

`default_nettype wire

// ===== test/gregorian_day_difference_weekday_test.sv =====
// Self-checking testbench for gregorian_day_difference_weekday: day differences and weekdays.
// Depends on gddw_pkg and the gregorian_day_difference_weekday module; needs no other files.
`default_nettype none

module gregorian_day_difference_weekday_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned RANDOM_PER_PHASE = 325;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int unsigned PRESSURE_AT   = 150;
    localparam int unsigned PRESSURE_HOLD = 80;

    // One query and one answer, at the widths of the block's ports.
    typedef struct {
        gddw_pkg::cmd_t                   command;
        logic [gddw_pkg::DAY_W-1:0]       a_day;
        logic [gddw_pkg::MONTH_W-1:0]     a_month;
        logic [gddw_pkg::YEAR_W-1:0]      a_year;
        logic [gddw_pkg::DAY_W-1:0]       b_day;
        logic [gddw_pkg::MONTH_W-1:0]     b_month;
        logic [gddw_pkg::YEAR_W-1:0]      b_year;
    } date_query_t;

    typedef struct {
        logic signed [gddw_pkg::DIFF_W-1:0] day_difference;
        logic [gddw_pkg::WD_W-1:0]          weekday;
    } date_answer_t;

    // Computes the calendar answers of accepted queries and holds them until
    // the block returns its own, oldest first.
    class date_answer_book;
        localparam longint DIFF_HI = 4194303;
        localparam longint DIFF_LO = -4194304;

        date_answer_t pending_answers[$];
        int unsigned  month_start[16];
        logic [gddw_pkg::YEAR_W-1:0] base_year;
        int unsigned  failures;
        int unsigned  checked_count;

        function new();
            month_start = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
                            365, 365, 365};
            base_year = gddw_pkg::BASE_YEAR_RESET;
            failures = 0;
            checked_count = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Absolute day number: days of all earlier years, earlier months and the day.
        function longint day_number(int unsigned d, int unsigned m, int unsigned y);
            int unsigned yc;
            longint      p;
            longint      days;
            yc = y;
            if (yc < 1)
            begin
                yc = 1;
            end
            if (yc > gddw_pkg::MAX_YEAR_DEFAULT)
            begin
                yc = gddw_pkg::MAX_YEAR_DEFAULT;
            end
            p = longint'(yc) - 1;
            days = 365 * p + p / 4 - p / 100 + p / 400;
            days += month_start[m & 15];
            if (leap_year(yc) && (m & 15) >= 3)
            begin
                days += 1;
            end
            return days + (d & 31);
        endfunction

        function date_answer_t predict(date_query_t q);
            date_answer_t ans;
            longint       na;
            longint       delta;
            longint       rem7;
            ans.day_difference = '0;
            ans.weekday = '0;
            na = day_number(32'(q.a_day), 32'(q.a_month), 32'(q.a_year));
            if (q.command == gddw_pkg::CMD_DIFF)
            begin
                delta = day_number(32'(q.b_day), 32'(q.b_month), 32'(q.b_year)) - na;
                if (delta > DIFF_HI)
                begin
                    delta = DIFF_HI;
                end
                if (delta < DIFF_LO)
                begin
                    delta = DIFF_LO;
                end
                ans.day_difference = delta[gddw_pkg::DIFF_W-1:0];
            end
            else
            begin
                // Dates before the base still give a remainder in 0..6.
                rem7 = (na - day_number(1, 1, 32'(base_year))) % 7;
                if (rem7 < 0)
                begin
                    rem7 += 7;
                end
                ans.weekday = rem7[gddw_pkg::WD_W-1:0];
            end
            return ans;
        endfunction

        function void set_base(logic [gddw_pkg::YEAR_W-1:0] y);
            base_year = y;
        endfunction

        function void note_query(date_query_t q);
            pending_answers.push_back(predict(q));
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction

        function void check_answer(logic signed [gddw_pkg::DIFF_W-1:0] diff,
                                   logic [gddw_pkg::WD_W-1:0] wd);
            date_answer_t exp_ans;
            checked_count++;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with none expected: diff %0d weekday %0d",
                         $realtime, diff, wd);
                failures++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (diff !== exp_ans.day_difference)
            begin
                $display("%0t: day_difference expected %0d actual %0d",
                         $realtime, exp_ans.day_difference, diff);
                failures++;
            end
            if (wd !== exp_ans.weekday)
            begin
                $display("%0t: weekday expected %0d actual %0d",
                         $realtime, exp_ans.weekday, wd);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [gddw_pkg::YEAR_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = 1'b0;
    logic [gddw_pkg::DAY_W-1:0]   a_day = '0;
    logic [gddw_pkg::MONTH_W-1:0] a_month = '0;
    logic [gddw_pkg::YEAR_W-1:0]  a_year = '0;
    logic [gddw_pkg::DAY_W-1:0]   b_day = '0;
    logic [gddw_pkg::MONTH_W-1:0] b_month = '0;
    logic [gddw_pkg::YEAR_W-1:0]  b_year = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [gddw_pkg::DIFF_W-1:0] day_difference;
    logic [gddw_pkg::WD_W-1:0] weekday;

    date_answer_book answers;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count = 0;

    gregorian_day_difference_weekday uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .a_day(a_day),
        .a_month(a_month),
        .a_year(a_year),
        .b_day(b_day),
        .b_month(b_month),
        .b_year(b_year),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .day_difference(day_difference),
        .weekday(weekday)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: none unless the idle percentage picks a gap; then mostly short, now and then long.
    function automatic int unsigned pick_gap(int unsigned idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic date_query_t make_query(gddw_pkg::cmd_t cmd,
                                               int unsigned ad, int unsigned am,
                                               int unsigned ay, int unsigned bd,
                                               int unsigned bm, int unsigned by);
        date_query_t q;
        q.command = cmd;
        q.a_day = ad[gddw_pkg::DAY_W-1:0];
        q.a_month = am[gddw_pkg::MONTH_W-1:0];
        q.a_year = ay[gddw_pkg::YEAR_W-1:0];
        q.b_day = bd[gddw_pkg::DAY_W-1:0];
        q.b_month = bm[gddw_pkg::MONTH_W-1:0];
        q.b_year = by[gddw_pkg::YEAR_W-1:0];
        return q;
    endfunction

    // A valid calendar year, spread over the whole range, the base, a neighbor
    // year and the century boundaries.
    function automatic int unsigned pick_year(int unsigned neighbor);
        int          y;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            y = $urandom_range(1, 9999);
        end
        else if (sel < 7)
        begin
            y = int'(answers.base_year) + $urandom_range(0, 800) - 400;
        end
        else if (sel == 7)
        begin
            y = int'(neighbor) + $urandom_range(0, 6) - 3;
        end
        else if (sel == 8)
        begin
            y = ($urandom_range(0, 1) == 0) ? 1 : 9999;
        end
        else
        begin
            y = $urandom_range(1, 99) * 100 + $urandom_range(0, 4) - 2;
        end
        if (y < 1)
        begin
            y = 1;
        end
        if (y > 9999)
        begin
            y = 9999;
        end
        return y;
    endfunction

    function automatic int unsigned pick_day(int unsigned m, int unsigned y);
        int unsigned last;
        case (m)
            2: last = date_answer_book::leap_year(y) ? 29 : 28;
            4, 6, 9, 11: last = 30;
            default: last = 31;
        endcase
        return ($urandom_range(0, 4) == 0) ? last : $urandom_range(1, last);
    endfunction

    // Mostly well-formed dates; the rest fills every field with raw bits.
    function automatic date_query_t random_query();
        date_query_t q;
        int unsigned ay;
        int unsigned am;
        int unsigned by;
        int unsigned bm;
        if ($urandom_range(0, 99) < 12)
        begin
            return make_query(gddw_pkg::cmd_t'($urandom_range(0, 1)),
                              $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
        end
        ay = pick_year(32'(answers.base_year));
        am = $urandom_range(1, 12);
        by = pick_year(ay);
        bm = $urandom_range(1, 12);
        q = make_query(gddw_pkg::cmd_t'($urandom_range(0, 1)),
                       pick_day(am, ay), am, ay, pick_day(bm, by), bm, by);
        return q;
    endfunction

    // Offers one query transaction and returns at the edge that accepts it.
    task automatic send_query(date_query_t q);
        int unsigned gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= q.command;
        a_day <= q.a_day;
        a_month <= q.a_month;
        a_year <= q.a_year;
        b_day <= q.b_day;
        b_month <= q.b_month;
        b_year <= q.b_year;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        answers.note_query(q);
    endtask

    // Lets every query drain, then writes the base year while the block is idle.
    task automatic write_base_year(logic [gddw_pkg::YEAR_W-1:0] y);
        in_valid <= 1'b0;
        while (answers.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= y;
        @(posedge clk);
        cfg_we <= 1'b0;
        answers.set_base(y);
    endtask

    task automatic run_directed();
        date_query_t list[$];
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 1, 1, 1, 1, 1));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 1, 1, 31, 12, 9999));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 31, 12, 9999, 1, 1, 1));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 28, 2, 2000, 1, 3, 2000));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 28, 2, 1900, 1, 3, 1900));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 1, 2000, 1, 1, 2400));
        // The later year first gives a negative difference.
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 3, 2024, 1, 3, 2023));
        // Zero fields and all-ones fields exercise both year clamps.
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 0, 0, 0, 31, 15, 16383));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 31, 15, 16383, 0, 0, 0));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 1, 10000, 1, 1, 9999));
        // A day past the end of its month is counted as given.
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 31, 2, 2023, 1, 3, 2023));
        // Month zero counts as January; months above twelve take the whole year.
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 5, 0, 1999, 5, 1, 1999));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 13, 2000, 1, 1, 2001));
        list.push_back(make_query(gddw_pkg::CMD_DIFF, 1, 14, 1999, 1, 15, 2000));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 1, 1, 1600, 0, 0, 0));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 31, 12, 1599, 31, 15, 16383));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 1, 1, 1, 1, 1, 1));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 31, 12, 9999, 31, 12, 9999));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 0, 0, 0, 31, 15, 16383));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 31, 15, 16383, 0, 0, 0));
        list.push_back(make_query(gddw_pkg::CMD_WEEKDAY, 29, 2, 2000, 1, 1, 1));
        foreach (list[i])
        begin
            send_query(list[i]);
        end
    endtask

    // Receiver: checks accepted answers and stalls at random, with one long
    // hold-off that backs the pipeline up into the input.
    initial
    begin : answer_drain
        int unsigned hold_left;
        int unsigned gap;
        bit          pressure_done;
        hold_left = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                answers.check_answer(day_difference, weekday);
            end
            if (!pressure_done && answers.checked_count >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                gap = pick_gap(recv_idle_pct);
                out_stall <= (gap > 0);
                if (gap > 0)
                begin
                    hold_left = gap - 1;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus: reset, directed queries, then random phases over several base years.
    initial
    begin : stimulus
        int unsigned send_pct[NUM_PHASES];
        int unsigned recv_pct[NUM_PHASES];
        logic [gddw_pkg::YEAR_W-1:0] bases[NUM_PHASES];
        send_pct = '{10, 0, 30, 20, 50, 15};
        recv_pct = '{20, 0, 10, 40, 30, 60};
        bases = '{gddw_pkg::BASE_YEAR_RESET, 14'd1, 14'd9999, 14'd0, 14'h3FFF, 14'd0};
        bases[NUM_PHASES-1] = gddw_pkg::YEAR_W'($urandom_range(1, 9999));
        answers = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // The first phase runs on the reset value of the base year.
            if (p > 0)
            begin
                write_base_year(bases[p]);
            end
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            if (p == 0)
            begin
                run_directed();
            end
            repeat (RANDOM_PER_PHASE) send_query(random_query());
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then allow a little longer for stray answers.
        while (answers.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (answers.failures == 0 && answers.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/gddw_pkg.sv
design/gregorian_day_difference_weekday.sv
test/gregorian_day_difference_weekday_test.sv
